// ===== rtl/core/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the point to polyline projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int ARC_BITS = 31;
   localparam logic [ARC_BITS-1:0] ARC_MAX = '1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LD0,
      S_LD0W,
      S_FETCH,
      S_SEG,
      S_M1,
      S_M2,
      S_M3,
      S_M4,
      S_M5,
      S_T,
      S_WAIT,
      S_F1,
      S_F2,
      S_F3,
      S_F4,
      S_F5,
      S_F6,
      S_ROOT,
      S_RWAIT,
      S_OUT
   } state_type;

endpackage

// ===== rtl/core/ppp_div_cell.sv =====
// ----------------------------------------------------------------------------
// ppp_div_cell
// One restoring division step; passes remainder, quotient and divisor on.
// ----------------------------------------------------------------------------
module ppp_div_cell
   import ppp_pkg::*;
#(
   parameter int RW = 51,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  logic [RW-1:0] rem_in,
   input  logic [QW-1:0] quo_in,
   input  logic [RW-1:0] div_in,
   output logic          valid_out,
   output logic [RW-1:0] rem_out,
   output logic [QW-1:0] quo_out,
   output logic [RW-1:0] div_out
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff;
   logic [QW-1:0] quo_ff;
   logic [RW-1:0] div_ff;
   logic [RW-1:0] shifted;
   logic          ge;

   assign shifted = {rem_in[RW-2:0], 1'b0};
   assign ge      = (shifted >= div_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff <= ge ? (shifted - div_in) : shifted;
      quo_ff <= {quo_in[QW-2:0], ge};
      div_ff <= div_in;
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign div_out   = div_ff;

endmodule

// ===== rtl/core/ppp_div_chain.sv =====
// ----------------------------------------------------------------------------
// ppp_div_chain
// Row of division cells, one quotient bit per cell, each cell registered.
// ----------------------------------------------------------------------------
module ppp_div_chain
   import ppp_pkg::*;
#(
   parameter int RW = 51,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [RW-1:0] dividend,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   logic          v_w [0:QW];
   logic [RW-1:0] r_w [0:QW];
   logic [QW-1:0] q_w [0:QW];
   logic [RW-1:0] d_w [0:QW];

   assign v_w[0] = start;
   assign r_w[0] = dividend;
   assign q_w[0] = '0;
   assign d_w[0] = divisor;

   for (genvar k = 0; k < QW; k++) begin : g_cell
      ppp_div_cell #(.RW(RW), .QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (v_w[k]),
         .rem_in    (r_w[k]),
         .quo_in    (q_w[k]),
         .div_in    (d_w[k]),
         .valid_out (v_w[k+1]),
         .rem_out   (r_w[k+1]),
         .quo_out   (q_w[k+1]),
         .div_out   (d_w[k+1])
      );
   end

   assign done     = v_w[QW];
   assign quotient = q_w[QW];

endmodule

// ===== rtl/core/ppp_isqrt.sv =====
// ----------------------------------------------------------------------------
// ppp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ppp_isqrt
   import ppp_pkg::*;
#(
   parameter int IW = 50
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [IW-1:0]      value,
   output logic               busy,
   output logic [IW/2-1:0]    root
);

   localparam int RW = IW / 2;
   localparam int CW = $clog2(RW + 1);

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] val_ff;
   logic [RW:0]   rem_ff;
   logic [RW-1:0] root_ff;
   logic [RW+2:0] rem_sh;
   logic [RW+2:0] trial;
   logic          ge;

   assign rem_sh = {rem_ff, val_ff[IW-1:IW-2]};
   assign trial  = (RW + 3)'({root_ff, 2'b01});
   assign ge     = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(RW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[IW-3:0], 2'b00};
         rem_ff  <= ge ? (RW + 1)'(rem_sh - trial) : (RW + 1)'(rem_sh);
         root_ff <= {root_ff[RW-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/point_to_polyline_projection.sv =====
// ----------------------------------------------------------------------------
// point_to_polyline_projection
// Stores a polyline and projects query points onto it.
// ----------------------------------------------------------------------------
// Clear and append are taken in S_IDLE. A query walks the segments one at a
// time. Each segment runs fetch and multiply steps on one shared multiplier.
// It also waits for the COORD_BITS+1 step square root and, if started, the
// T_FRACTION_BITS-cell divider row, whichever finishes later. A final
// COORD_BITS+1 step square root follows the last segment. A query with fewer
// than two vertices stored skips the walk and answers with rsp_valid_res low.
// One transaction is in flight at a time.
// ----------------------------------------------------------------------------
module point_to_polyline_projection
   import ppp_pkg::*;
#(
   parameter int MAX_VERTICES    = 64,
   parameter int COORD_BITS      = 24,
   parameter int T_FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_valid_res,
   output logic [COORD_BITS:0]          rsp_lateral_distance,
   output logic [ARC_BITS-1:0]          rsp_arc_length,
   output logic signed [COORD_BITS-1:0] rsp_nearest_x,
   output logic signed [COORD_BITS-1:0] rsp_nearest_y
);

   localparam int C    = COORD_BITS;
   localparam int T    = T_FRACTION_BITS;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int VW   = $clog2(MAX_VERTICES + 1);
   localparam int SW   = 2 * C + 2;
   localparam int DW   = 2 * C + 3;
   localparam int MW   = (C > T) ? C + 2 : T + 2;
   localparam int PW   = 2 * MW;
   localparam int LW   = C + 1;
   localparam int TW   = T + 1;
   localparam int SUMW = (LW < ARC_BITS) ? ARC_BITS + 1 : LW + 1;
   localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (T - 1));
   localparam logic [TW-1:0] T_ONE = TW'(64'd1 << T);

   state_type state_ff, state_in;

   logic [C-1:0]  mem_x [MAX_VERTICES];
   logic [C-1:0]  mem_y [MAX_VERTICES];
   logic [C-1:0]  rd_x_ff, rd_y_ff;
   logic [AW-1:0] rd_addr;

   logic [VW-1:0]        count_ff;
   logic [AW-1:0]        idx_ff;
   logic signed [C-1:0]  q_x_ff, q_y_ff, p0x_ff, p0y_ff, p1x_ff, p1y_ff;
   logic signed [C:0]    dx_ff, dy_ff, ux_ff, uy_ff;
   logic [SW-1:0]        seg_ff, sq_ff, best_sq_ff, sq_sum;
   logic signed [DW-1:0] dot_ff, seg_ext;
   logic [TW-1:0]        t_ff;
   logic                 tdone_ff;
   logic [LW-1:0]        len_ff, arcp_ff, lat_ff;
   logic signed [C-1:0]  fx_ff, fy_ff, best_x_ff, best_y_ff;
   logic [ARC_BITS-1:0]  best_arc_ff, acc_ff, arc_cand, acc_next;
   logic [SUMW-1:0]      arc_sum, acc_sum;
   logic                 ok_ff;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_ff, rnd_full;
   logic signed [C:0]    rnd, ex, ey;

   logic                 accept, last_seg, slot_free;
   logic                 div_start, div_done;
   logic [T-1:0]         div_quo;
   logic                 sq_start, sq_busy;
   logic [SW-1:0]        sq_value;
   logic [LW-1:0]        sq_root;

   logic                 rsp_valid_ff, rsp_res_ff;
   logic [LW-1:0]        rsp_lat_ff;
   logic [ARC_BITS-1:0]  rsp_arc_ff;
   logic signed [C-1:0]  rsp_x_ff, rsp_y_ff;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_seg  = (VW'(idx_ff) == count_ff - VW'(1));
   assign rd_addr   = (state_ff == S_FETCH) ? idx_ff : '0;

   assign seg_ext  = $signed({1'b0, seg_ff});
   assign rnd_full = (mul_ff + HALF) >>> T;
   assign rnd      = rnd_full[C:0];
   assign ex       = $signed({q_x_ff[C-1], q_x_ff}) - $signed({fx_ff[C-1], fx_ff});
   assign ey       = $signed({q_y_ff[C-1], q_y_ff}) - $signed({fy_ff[C-1], fy_ff});
   assign sq_sum   = sq_ff + mul_ff[SW-1:0];
   assign arc_sum  = SUMW'(acc_ff) + SUMW'(arcp_ff);
   assign acc_sum  = SUMW'(acc_ff) + SUMW'(len_ff);
   assign arc_cand = (arc_sum > SUMW'(ARC_MAX)) ? ARC_MAX : arc_sum[ARC_BITS-1:0];
   assign acc_next = (acc_sum > SUMW'(ARC_MAX)) ? ARC_MAX : acc_sum[ARC_BITS-1:0];

   assign div_start = (state_ff == S_T) && (seg_ff != '0) && (dot_ff > DW'(0))
                      && (dot_ff < seg_ext);
   assign sq_start  = (state_ff == S_T) || (state_ff == S_ROOT);
   assign sq_value  = (state_ff == S_ROOT) ? best_sq_ff : seg_ff;

   ppp_div_chain #(.RW(SW + 1), .QW(T)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({1'b0, dot_ff[SW-1:0]}),
      .divisor  ({1'b0, seg_ff}),
      .done     (div_done),
      .quotient (div_quo)
   );

   ppp_isqrt #(.IW(SW)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M1: begin mul_a = MW'(dx_ff); mul_b = MW'(dx_ff); end
         S_M2: begin mul_a = MW'(dy_ff); mul_b = MW'(dy_ff); end
         S_M3: begin mul_a = MW'(ux_ff); mul_b = MW'(dx_ff); end
         S_M4: begin mul_a = MW'(uy_ff); mul_b = MW'(dy_ff); end
         S_F1: begin mul_a = MW'($signed({1'b0, t_ff})); mul_b = MW'(dx_ff); end
         S_F2: begin mul_a = MW'($signed({1'b0, t_ff})); mul_b = MW'(dy_ff); end
         S_F3: begin
            mul_a = MW'($signed({1'b0, t_ff}));
            mul_b = MW'($signed({1'b0, len_ff}));
         end
         S_F4: begin mul_a = MW'(ex); mul_b = MW'(ex); end
         S_F5: begin mul_a = MW'(ey); mul_b = MW'(ey); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_cmd == CMD_QUERY)) begin
               state_in = (count_ff < VW'(2)) ? S_OUT : S_LD0;
            end
         end
         S_LD0:   state_in = S_LD0W;
         S_LD0W:  state_in = S_FETCH;
         S_FETCH: state_in = S_SEG;
         S_SEG:   state_in = S_M1;
         S_M1:    state_in = S_M2;
         S_M2:    state_in = S_M3;
         S_M3:    state_in = S_M4;
         S_M4:    state_in = S_M5;
         S_M5:    state_in = S_T;
         S_T:     state_in = S_WAIT;
         S_WAIT: begin
            if (tdone_ff && !sq_busy) begin
               state_in = S_F1;
            end
         end
         S_F1:    state_in = S_F2;
         S_F2:    state_in = S_F3;
         S_F3:    state_in = S_F4;
         S_F4:    state_in = S_F5;
         S_F5:    state_in = S_F6;
         S_F6:    state_in = last_seg ? S_ROOT : S_FETCH;
         S_ROOT:  state_in = S_RWAIT;
         S_RWAIT: begin
            if (!sq_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // vertex store
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_APPEND) && (count_ff < VW'(MAX_VERTICES))) begin
         mem_x[count_ff[AW-1:0]] <= req_point_x;
         mem_y[count_ff[AW-1:0]] <= req_point_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         priority if (req_cmd == CMD_CLEAR) begin
            count_ff <= '0;
         end else if ((req_cmd == CMD_APPEND) && (count_ff < VW'(MAX_VERTICES))) begin
            count_ff <= count_ff + VW'(1);
         end else begin
            count_ff <= count_ff;
         end
      end
   end

   // segment datapath
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (div_done) begin
         t_ff     <= {1'b0, div_quo};
         tdone_ff <= 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            q_x_ff <= req_point_x;
            q_y_ff <= req_point_y;
            ok_ff  <= (count_ff >= VW'(2));
         end
         S_LD0W: begin
            p0x_ff <= rd_x_ff;
            p0y_ff <= rd_y_ff;
            idx_ff <= AW'(1);
            acc_ff <= '0;
         end
         S_SEG: begin
            p1x_ff <= rd_x_ff;
            p1y_ff <= rd_y_ff;
            dx_ff  <= $signed({rd_x_ff[C-1], rd_x_ff}) - $signed({p0x_ff[C-1], p0x_ff});
            dy_ff  <= $signed({rd_y_ff[C-1], rd_y_ff}) - $signed({p0y_ff[C-1], p0y_ff});
            ux_ff  <= $signed({q_x_ff[C-1], q_x_ff}) - $signed({p0x_ff[C-1], p0x_ff});
            uy_ff  <= $signed({q_y_ff[C-1], q_y_ff}) - $signed({p0y_ff[C-1], p0y_ff});
         end
         S_M2: seg_ff <= mul_ff[SW-1:0];
         S_M3: seg_ff <= seg_ff + mul_ff[SW-1:0];
         S_M4: dot_ff <= mul_ff[DW-1:0];
         S_M5: dot_ff <= dot_ff + mul_ff[DW-1:0];
         S_T: begin
            if ((seg_ff == '0) || (dot_ff <= DW'(0))) begin
               t_ff     <= '0;
               tdone_ff <= 1'b1;
            end else if (dot_ff >= seg_ext) begin
               t_ff     <= T_ONE;
               tdone_ff <= 1'b1;
            end else begin
               tdone_ff <= 1'b0;
            end
         end
         S_WAIT: len_ff <= sq_root;
         S_F2: fx_ff <= C'(rnd + $signed({p0x_ff[C-1], p0x_ff}));
         S_F3: fy_ff <= C'(rnd + $signed({p0y_ff[C-1], p0y_ff}));
         S_F4: arcp_ff <= rnd[LW-1:0];
         S_F5: sq_ff <= mul_ff[SW-1:0];
         S_F6: begin
            if ((idx_ff == AW'(1)) || (sq_sum < best_sq_ff)) begin
               best_sq_ff  <= sq_sum;
               best_x_ff   <= fx_ff;
               best_y_ff   <= fy_ff;
               best_arc_ff <= arc_cand;
            end
            acc_ff <= acc_next;
            p0x_ff <= p1x_ff;
            p0y_ff <= p1y_ff;
            idx_ff <= idx_ff + AW'(1);
         end
         S_RWAIT: lat_ff <= sq_root;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == S_OUT) && slot_free) begin
         rsp_res_ff <= ok_ff;
         rsp_lat_ff <= ok_ff ? lat_ff : '0;
         rsp_arc_ff <= ok_ff ? best_arc_ff : '0;
         rsp_x_ff   <= ok_ff ? best_x_ff : '0;
         rsp_y_ff   <= ok_ff ? best_y_ff : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_valid_res        = rsp_res_ff;
   assign rsp_lateral_distance = rsp_lat_ff;
   assign rsp_arc_length       = rsp_arc_ff;
   assign rsp_nearest_x        = rsp_x_ff;
   assign rsp_nearest_y        = rsp_y_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= VW'(MAX_VERTICES))
      else $error("vertex count above store depth");

   a_div_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WAIT))
      else $error("divider result outside wait state");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_lateral_distance == '0)
      && (rsp_arc_length == '0))
      else $error("invalid result with nonzero fields");

   a_t_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F1) |-> (t_ff <= T_ONE))
      else $error("projection parameter above one");

endmodule
